[rtl/core/cfa_pkg.sv]
// package for the custom float alu: widths, codes and state types
package cfa_pkg;

	localparam int unsigned MantWidth = 32;
	localparam int unsigned ExpWidth  = 8;
	localparam logic [ExpWidth-1:0] ExpNan = 8'd255;
	localparam int unsigned PreShift = 32;
	localparam int unsigned WideWidth = 64;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_EXACT    = 2'd0,
		ST_INEXACT  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ALIGN_L,
		S_ALIGN_R,
		S_ADD,
		S_MUL,
		S_DIV_PRE,
		S_DIV,
		S_DIV_POST,
		S_DIV_RSH,
		S_FIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic               sign;
		logic [ExpWidth-1:0] exp;
		logic [MantWidth-1:0] mant;
	} num_t;

	typedef struct packed {
		logic               sign;
		logic [ExpWidth-1:0] exp;
		logic [MantWidth-1:0] mant;
		status_t            status;
	} res_t;

endpackage

[rtl/core/cfa_if.sv]
// valid/ready channel interface carrying a packed payload
interface cfa_if #(parameter int unsigned W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/custom_float_alu.sv]
// custom float alu top: input capture, iterative core, output register
// throughput: one transaction at a time; input ready is low while an operation runs
//   or while the result register holds a result not yet taken
// reset: arst_n clears the sequencer, the busy flag and the output valid, no data state
module custom_float_alu (
	input  logic clk,
	input  logic arst_n,
	cfa_if.sink   in_ch,
	cfa_if.source out_ch
);

	logic          busy_q;
	logic          out_valid_q;
	cfa_pkg::res_t out_q;
	logic          done;
	cfa_pkg::res_t res;
	cfa_pkg::num_t a_in, b_in;
	logic          start;

	// input unpack: action, a sign/exp/mant, b sign/exp/mant
	assign a_in  = in_ch.data[81:41];
	assign b_in  = in_ch.data[40:0];
	assign start = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !busy_q && !out_valid_q;

	cfa_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (in_ch.data[83:82]),
		.a_in   (a_in),
		.b_in   (b_in),
		.done   (done),
		.res    (res)
	);

	// busy and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) busy_q <= 1'b1;
			else if (done) busy_q <= 1'b0;
			if (done) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) out_q <= res;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_ch.ready)
		else $error("ready while busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q)
		else $error("done while idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_q))
		else $error("result dropped");
`endif

endmodule

[rtl/core/cfa_core.sv]
// iterative datapath and sequencer: each step uses its own shift or add/subtract logic
module cfa_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     action,
	input  cfa_pkg::num_t  a_in,
	input  cfa_pkg::num_t  b_in,
	output logic           done,
	output cfa_pkg::res_t  res
);

	localparam int unsigned W  = cfa_pkg::MantWidth;
	localparam int unsigned WW = cfa_pkg::WideWidth;
	localparam int unsigned EW = cfa_pkg::ExpWidth;

	cfa_pkg::state_t state_q, state_d;

	logic [1:0]    act_q;
	logic          as_q, bs_q, rs_q;
	logic [EW:0]   ae_q, be_q;
	logic [WW-1:0] am_q, bm_q;
	logic [WW-1:0] acc_q;
	logic [W-1:0]  rem_q;
	logic [6:0]    cnt_q;
	logic [EW+1:0] re_q;
	logic          lost_q;
	cfa_pkg::status_t st_q;
	logic [W-1:0]  rm_q;
	logic          left_q;

	// combinational helpers: a wide add, a narrow trial subtract and compares
	logic [WW:0]   sum_w;
	logic [W:0]    trial_w;
	logic          a_gt_b;
	logic          a_top, b_top;

	assign a_top  = am_q[W-1];
	assign b_top  = bm_q[W-1];
	assign a_gt_b = am_q > bm_q;
	assign trial_w = {rem_q, acc_q[WW-1]} - {1'b0, bm_q[W-1:0]};
	assign sum_w  = {1'b0, am_q} + {1'b0, bm_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cfa_pkg::S_IDLE: if (start) state_d = cfa_pkg::S_DISPATCH;
			cfa_pkg::S_DISPATCH: begin
				if (ae_q >= {1'b0, cfa_pkg::ExpNan} || be_q >= {1'b0, cfa_pkg::ExpNan})
					state_d = cfa_pkg::S_DONE;
				else if (act_q == cfa_pkg::ACT_MUL)
					state_d = (am_q == '0 || bm_q == '0) ? cfa_pkg::S_DONE : cfa_pkg::S_MUL;
				else if (act_q == cfa_pkg::ACT_DIV)
					state_d = (bm_q == '0 || am_q == '0) ? cfa_pkg::S_DONE
						: cfa_pkg::S_DIV_PRE;
				else
					state_d = (am_q == '0 || bm_q == '0) ? cfa_pkg::S_DONE
						: cfa_pkg::S_ALIGN_L;
			end
			cfa_pkg::S_ALIGN_L: begin
				if (ae_q == be_q) state_d = cfa_pkg::S_ADD;
				else if (ae_q > be_q ? a_top : b_top) state_d = cfa_pkg::S_ALIGN_R;
			end
			cfa_pkg::S_ALIGN_R: if (ae_q == be_q) state_d = cfa_pkg::S_ADD;
			cfa_pkg::S_ADD: state_d = cfa_pkg::S_FIT;
			cfa_pkg::S_MUL: if (cnt_q == 7'(W - 1)) state_d = cfa_pkg::S_FIT;
			cfa_pkg::S_DIV_PRE: if (ae_q <= be_q || a_top) state_d = cfa_pkg::S_DIV;
			cfa_pkg::S_DIV: if (cnt_q == 7'(WW - 1)) state_d = cfa_pkg::S_DIV_POST;
			cfa_pkg::S_DIV_POST: state_d = left_q ? cfa_pkg::S_DIV_RSH : cfa_pkg::S_FIT;
			cfa_pkg::S_DIV_RSH: if (cnt_q == '0) state_d = cfa_pkg::S_DONE;
			cfa_pkg::S_FIT: if (acc_q[WW-1:W] == '0) state_d = cfa_pkg::S_DONE;
			cfa_pkg::S_DONE: state_d = cfa_pkg::S_IDLE;
			default: state_d = cfa_pkg::S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cfa_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			cfa_pkg::S_IDLE: begin
				if (start) begin
					act_q <= action;
					as_q  <= a_in.sign;
					ae_q  <= {1'b0, a_in.exp};
					am_q  <= {{(WW-W){1'b0}}, a_in.mant};
					bs_q  <= b_in.sign ^ (action == cfa_pkg::ACT_SUB);
					be_q  <= {1'b0, b_in.exp};
					bm_q  <= {{(WW-W){1'b0}}, b_in.mant};
				end
			end
			cfa_pkg::S_DISPATCH: begin
				rs_q   <= as_q;
				re_q   <= {1'b0, ae_q};
				rm_q   <= am_q[W-1:0];
				st_q   <= cfa_pkg::ST_EXACT;
				lost_q <= 1'b0;
				cnt_q  <= '0;
				acc_q  <= '0;
				rem_q  <= '0;
				left_q <= 1'b0;
				if (ae_q >= {1'b0, cfa_pkg::ExpNan} || be_q >= {1'b0, cfa_pkg::ExpNan}) begin
					re_q <= {2'b0, cfa_pkg::ExpNan};
					rm_q <= '0;
				end else if (act_q == cfa_pkg::ACT_MUL || act_q == cfa_pkg::ACT_DIV) begin
					if (act_q == cfa_pkg::ACT_DIV && bm_q == '0) begin
						re_q <= {2'b0, cfa_pkg::ExpNan};
						rm_q <= '0;
					end else if (am_q == '0 || bm_q == '0) begin
						re_q <= '0;
						rm_q <= '0;
					end else begin
						rs_q <= as_q ^ bs_q;
						if (act_q == cfa_pkg::ACT_MUL) re_q <= {1'b0, ae_q} + {1'b0, be_q};
					end
				end else if (am_q == '0) begin
					rs_q <= bs_q;
					re_q <= {1'b0, be_q};
					rm_q <= bm_q[W-1:0];
				end
			end
			// loss-free left shift of the larger-exponent operand, one bit a cycle
			cfa_pkg::S_ALIGN_L: begin
				if (ae_q > be_q && !a_top) begin
					am_q <= {am_q[WW-2:0], 1'b0};
					ae_q <= ae_q - 1'b1;
				end else if (be_q > ae_q && !b_top) begin
					bm_q <= {bm_q[WW-2:0], 1'b0};
					be_q <= be_q - 1'b1;
				end
			end
			// forced right shift of the other operand
			cfa_pkg::S_ALIGN_R: begin
				if (ae_q > be_q) begin
					bm_q <= bm_q >> 1;
					be_q <= be_q + 1'b1;
				end else if (be_q > ae_q) begin
					am_q <= am_q >> 1;
					ae_q <= ae_q + 1'b1;
				end
			end
			cfa_pkg::S_ADD: begin
				rs_q <= as_q;
				re_q <= {1'b0, ae_q};
				if (as_q != bs_q) begin
					acc_q <= a_gt_b ? am_q - bm_q : bm_q - am_q;
					if (!a_gt_b) rs_q <= bs_q;
				end else begin
					acc_q <= sum_w[WW-1:0];
				end
			end
			// shift-and-add multiply, one multiplier bit a cycle
			cfa_pkg::S_MUL: begin
				if (bm_q[cnt_q[5:0]]) acc_q <= acc_q + (am_q << cnt_q[4:0]);
				cnt_q <= cnt_q + 1'b1;
			end
			// loss-free left shift of the dividend toward the divisor exponent, then load of the pre-shifted dividend
			cfa_pkg::S_DIV_PRE: begin
				if (ae_q > be_q && !a_top) begin
					am_q <= {am_q[WW-2:0], 1'b0};
					ae_q <= ae_q - 1'b1;
				end else begin
					if (ae_q <= be_q) begin
						left_q <= 1'b1;
						acc_q  <= am_q;
					end else if (ae_q - be_q <= 9'(cfa_pkg::PreShift)) begin
						acc_q <= am_q << (ae_q - be_q);
						re_q  <= '0;
					end else begin
						acc_q <= am_q << cfa_pkg::PreShift;
						re_q  <= {1'b0, ae_q - be_q - 9'(cfa_pkg::PreShift)};
					end
				end
			end
			// restoring division, one quotient bit a cycle
			cfa_pkg::S_DIV: begin
				if (!trial_w[W]) begin
					rem_q <= trial_w[W-1:0];
					acc_q <= {acc_q[WW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[W-2:0], acc_q[WW-1]};
					acc_q <= {acc_q[WW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			cfa_pkg::S_DIV_POST: begin
				if (left_q) begin
					re_q <= '0;
					rm_q <= acc_q[W-1:0];
					if (be_q - ae_q >= 9'(W)) begin
						rm_q  <= '0;
						cnt_q <= '0;
					end else begin
						cnt_q <= 7'(be_q - ae_q);
					end
				end
			end
			cfa_pkg::S_DIV_RSH: begin
				if (cnt_q != '0) begin
					rm_q  <= rm_q >> 1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			// cut back to mantissa width, one bit a cycle, then overflow check
			cfa_pkg::S_FIT: begin
				if (acc_q[WW-1:W] != '0) begin
					acc_q  <= acc_q >> 1;
					lost_q <= lost_q | acc_q[0];
					re_q   <= re_q + 1'b1;
				end else begin
					if (re_q >= {2'b0, cfa_pkg::ExpNan}) begin
						re_q <= {2'b0, cfa_pkg::ExpNan};
						rm_q <= '0;
						st_q <= cfa_pkg::ST_OVERFLOW;
					end else begin
						rm_q <= acc_q[W-1:0];
						st_q <= lost_q ? cfa_pkg::ST_INEXACT : cfa_pkg::ST_EXACT;
					end
				end
			end
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		done       = state_q == cfa_pkg::S_DONE;
		res.sign   = rs_q;
		res.exp    = re_q[EW-1:0];
		res.mant   = rm_q;
		res.status = st_q;
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && state_q == cfa_pkg::S_IDLE |=> state_q == cfa_pkg::S_DISPATCH)
		else $error("start not taken");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held");
	a_ovf_nan: assert property (@(posedge clk) disable iff (!arst_n)
		done && st_q == cfa_pkg::ST_OVERFLOW |-> re_q[EW-1:0] == cfa_pkg::ExpNan && rm_q == '0)
		else $error("overflow without nan");
`endif

endmodule

[sim/testbench.sv]
// self-checking testbench for custom_float_alu: directed and random operations
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		cfa_pkg::action_t act;
		cfa_pkg::num_t    a;
		cfa_pkg::num_t    b;
	} op_t;

	// wide working copy of an operand
	typedef struct {
		bit          s;
		int unsigned e;
		logic [63:0] m;
	} wnum_t;

	localparam logic [63:0] MaskM = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] TopM  = 64'h0000_0000_8000_0000;
	localparam int unsigned EN    = 255;

	logic clk;
	logic arst_n;
	logic hold;
	int   n_err;
	cfa_pkg::res_t result_q[$];

	cfa_if #(.W($bits(op_t)))           in_ch ();
	cfa_if #(.W($bits(cfa_pkg::res_t))) out_ch ();

	custom_float_alu u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#50ms;
		$display("testbench: FAIL");
		$finish;
	end

	// cut a wide value back to 32 bits
	function automatic logic [63:0] fit32(input logic [63:0] x, output int unsigned sh,
			output bit lost);
		int p;
		sh = 0;
		lost = 1'b0;
		if (x <= MaskM) return x;
		p = 63;
		while (p > 0 && x[p] == 1'b0) p--;
		sh = p - 31;
		lost = (x & ((64'd1 << sh) - 64'd1)) != 64'd0;
		return x >> sh;
	endfunction

	// move exponent toward z, right shifts stop at a set bit unless forced
	function automatic bit move_toward(ref wnum_t x, input int unsigned z, input bit forced);
		while (x.e < z && (forced || x.m[0] == 1'b0)) begin
			x.m = x.m >> 1;
			x.e++;
		end
		while (x.e > z && (x.m & TopM) == 64'd0) begin
			x.m = (x.m << 1) & MaskM;
			x.e--;
		end
		return x.e == z;
	endfunction

	// expected result of one operation
	function automatic cfa_pkg::res_t alu_result(input op_t op);
		wnum_t a, b, r;
		cfa_pkg::status_t st;
		logic [63:0] w, cut;
		int unsigned sh, e, base, d;
		bit lost, nan;
		a.s = op.a.sign; a.e = 32'(op.a.exp); a.m = {32'd0, op.a.mant};
		b.s = op.b.sign; b.e = 32'(op.b.exp); b.m = {32'd0, op.b.mant};
		if (op.act == cfa_pkg::ACT_SUB) b.s = ~b.s;
		r = a;
		st = cfa_pkg::ST_EXACT;
		nan = 1'b0;
		if (a.e >= EN || b.e >= EN) begin
			nan = 1'b1;
		end else if (op.act == cfa_pkg::ACT_ADD || op.act == cfa_pkg::ACT_SUB) begin
			if (a.m == 0) r = b;
			else if (b.m == 0) r = a;
			else begin
				if (a.e > b.e) begin
					if (!move_toward(a, b.e, 1'b0)) void'(move_toward(b, a.e, 1'b1));
				end else if (a.e < b.e) begin
					if (!move_toward(b, a.e, 1'b0)) void'(move_toward(a, b.e, 1'b1));
				end
				r = a;
				if (a.s != b.s) begin
					if (a.m > b.m) r.m = a.m - b.m;
					else begin
						r.s = b.s;
						r.m = b.m - a.m;
					end
				end else begin
					w = a.m + b.m;
					if (w <= MaskM) r.m = w;
					else begin
						cut = fit32(w, sh, lost);
						if (a.e + sh < EN) begin
							r.m = cut;
							r.e = a.e + sh;
							st = lost ? cfa_pkg::ST_INEXACT : cfa_pkg::ST_EXACT;
						end else begin
							nan = 1'b1;
							st = cfa_pkg::ST_OVERFLOW;
						end
					end
				end
			end
		end else if (op.act == cfa_pkg::ACT_MUL) begin
			if (a.m == 0 || b.m == 0) begin
				r.e = 0;
				r.m = 0;
			end else begin
				r.s = a.s ^ b.s;
				e = a.e + b.e;
				w = a.m * b.m;
				if (e >= EN) begin
					nan = 1'b1;
					st = cfa_pkg::ST_OVERFLOW;
				end else if (w <= MaskM) begin
					r.e = e;
					r.m = w;
				end else begin
					cut = fit32(w, sh, lost);
					e += sh;
					if (e >= EN) begin
						nan = 1'b1;
						st = cfa_pkg::ST_OVERFLOW;
					end else begin
						r.e = e;
						r.m = cut;
						st = lost ? cfa_pkg::ST_INEXACT : cfa_pkg::ST_EXACT;
					end
				end
			end
		end else begin
			if (b.m == 0) nan = 1'b1;
			else if (a.m == 0) begin
				r.e = 0;
				r.m = 0;
			end else begin
				r.s = a.s ^ b.s;
				if (a.e != b.e) void'(move_toward(a, b.e, 1'b0));
				if (a.e <= b.e) begin
					d = b.e - a.e;
					r.e = 0;
					r.m = (d >= 32) ? 64'd0 : ((a.m / b.m) >> d);
				end else begin
					if (a.e - b.e <= cfa_pkg::PreShift) begin
						w = (a.m << (a.e - b.e)) / b.m;
						base = 0;
					end else begin
						w = (a.m << cfa_pkg::PreShift) / b.m;
						base = a.e - b.e - cfa_pkg::PreShift;
					end
					cut = fit32(w, sh, lost);
					if (base + sh >= EN) begin
						nan = 1'b1;
						st = cfa_pkg::ST_OVERFLOW;
					end else begin
						r.e = base + sh;
						r.m = cut;
						st = lost ? cfa_pkg::ST_INEXACT : cfa_pkg::ST_EXACT;
					end
				end
			end
		end
		if (nan) begin
			r.e = EN;
			r.m = 0;
		end
		return '{sign: r.s, exp: r.e[7:0], mant: r.m[31:0], status: st};
	endfunction

	// receiver stall pattern, overridden by a long hold-off
	int unsigned rx_mode;
	int unsigned rx_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_mode <= 0;
			rx_cnt <= 0;
		end else begin
			rx_cnt <= rx_cnt + 1;
			if (rx_cnt % 300 == 299) rx_mode <= $urandom_range(0, 3);
			case (rx_mode)
				0: out_ch.ready <= !hold;
				1: out_ch.ready <= !hold && ($urandom_range(0, 1) == 0);
				2: out_ch.ready <= !hold && ($urandom_range(0, 7) == 0);
				default: out_ch.ready <= !hold && (rx_cnt[3:2] != 2'b11);
			endcase
		end
	end

	// long receiver hold-off, counted here
	event hold_go;
	initial begin
		hold = 1'b0;
		forever begin
			@(hold_go);
			hold <= 1'b1;
			repeat (400) @(posedge clk);
			hold <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		cfa_pkg::res_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = cfa_pkg::res_t'(out_ch.data);
			if (result_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected result %p", got);
			end else begin
				want = result_q.pop_front();
				if (got.sign !== want.sign || got.exp !== want.exp || got.mant !== want.mant ||
						got.status !== want.status) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// offer one transaction and wait until it is taken
	task automatic send_op(input op_t op);
		in_ch.data <= op;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		result_q.push_back(alu_result(op));
	endtask

	task automatic go_idle(input int unsigned cycles);
		in_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic op_t mk(input cfa_pkg::action_t act, input bit as, input int unsigned ae,
			input logic [31:0] am, input bit bs, input int unsigned be, input logic [31:0] bm);
		return '{act: act, a: '{as, ae[7:0], am}, b: '{bs, be[7:0], bm}};
	endfunction

	function automatic cfa_pkg::num_t rand_num();
		cfa_pkg::num_t n;
		int unsigned len;
		n.sign = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: n.exp = 8'($urandom_range(0, 255));
			1: n.exp = 8'($urandom_range(200, 255));
			2: n.exp = 8'd255;
			default: n.exp = 8'($urandom_range(0, 40));
		endcase
		len = $urandom_range(0, 32);
		n.mant = (len == 32) ? $urandom() : ($urandom() & ((32'd1 << len) - 32'd1));
		if ($urandom_range(0, 15) == 0) n.mant = 32'hFFFF_FFFF;
		return n;
	endfunction

	function automatic op_t rand_op();
		op_t op;
		op.act = cfa_pkg::action_t'($urandom_range(0, 3));
		op.a = rand_num();
		op.b = rand_num();
		if ($urandom_range(0, 15) == 0) op.b = '{~op.a.sign, op.a.exp, op.a.mant};
		if ($urandom_range(0, 15) == 0) op.b.exp = op.a.exp;
		return op;
	endfunction

	// special cases and field extremes
	task automatic test_directed();
		send_op(mk(cfa_pkg::ACT_ADD, 0, 3, 32'd5, 0, 3, 32'd7));
		send_op(mk(cfa_pkg::ACT_SUB, 0, 3, 32'd5, 0, 3, 32'd9));
		send_op(mk(cfa_pkg::ACT_ADD, 0, 4, 32'd12, 1, 4, 32'd12));
		send_op(mk(cfa_pkg::ACT_SUB, 1, 4, 32'd12, 1, 4, 32'd12));
		send_op(mk(cfa_pkg::ACT_ADD, 1, 255, 32'd1, 0, 0, 32'd1));
		send_op(mk(cfa_pkg::ACT_MUL, 0, 0, 32'd1, 1, 255, 32'hFFFF_FFFF));
		send_op(mk(cfa_pkg::ACT_SUB, 0, 0, 32'd0, 0, 9, 32'd77));
		send_op(mk(cfa_pkg::ACT_ADD, 1, 9, 32'd77, 0, 2, 32'd0));
		send_op(mk(cfa_pkg::ACT_ADD, 0, 5, 32'h8000_0001, 0, 0, 32'd3));
		send_op(mk(cfa_pkg::ACT_ADD, 0, 0, 32'd3, 1, 40, 32'hC000_0000));
		send_op(mk(cfa_pkg::ACT_ADD, 0, 10, 32'hFFFF_FFFF, 0, 10, 32'hFFFF_FFFF));
		send_op(mk(cfa_pkg::ACT_ADD, 1, 254, 32'hFFFF_FFFF, 1, 254, 32'hFFFF_FFFF));
		send_op(mk(cfa_pkg::ACT_MUL, 1, 0, 32'd0, 0, 7, 32'd9));
		send_op(mk(cfa_pkg::ACT_MUL, 0, 200, 32'd3, 1, 100, 32'd3));
		send_op(mk(cfa_pkg::ACT_MUL, 0, 1, 32'hFFFF_FFFF, 1, 2, 32'hFFFF_FFFF));
		send_op(mk(cfa_pkg::ACT_MUL, 1, 127, 32'h8000_0000, 1, 127, 32'h8000_0000));
		send_op(mk(cfa_pkg::ACT_MUL, 0, 100, 32'd6, 0, 20, 32'd7));
		send_op(mk(cfa_pkg::ACT_DIV, 1, 5, 32'd100, 0, 5, 32'd0));
		send_op(mk(cfa_pkg::ACT_DIV, 1, 5, 32'd0, 0, 5, 32'd3));
		send_op(mk(cfa_pkg::ACT_DIV, 0, 0, 32'd1000, 1, 3, 32'd7));
		send_op(mk(cfa_pkg::ACT_DIV, 0, 0, 32'd1000, 0, 60, 32'd7));
		send_op(mk(cfa_pkg::ACT_DIV, 0, 254, 32'hFFFF_FFFF, 0, 0, 32'd1));
		send_op(mk(cfa_pkg::ACT_DIV, 1, 20, 32'h8000_0000, 0, 2, 32'd3));
		send_op(mk(cfa_pkg::ACT_DIV, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF));
		go_idle(1);
	endtask

	// random operations in bursts with random gaps
	task automatic test_random(input int unsigned count);
		int unsigned sent, burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				send_op(rand_op());
				sent++;
			end
			if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 25));
		end
		go_idle(1);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		@(posedge clk);
		-> hold_go;
		repeat (6) send_op(rand_op());
		go_idle(1);
		while (result_q.size() != 0) @(posedge clk);
		repeat (6) send_op(rand_op());
		go_idle(1);
	endtask

	initial begin
		n_err = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(1000);
		test_backpressure();
		test_random(900);
		while (result_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (n_err == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
